### sv/dsd_pkg.sv
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and constants for the escape/start/end byte-stuffing deframer.
// ----------------------------------------------------------------------------
package dsd_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_ESCAPE = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_END    = 2'd2;
    localparam logic [1:0] REG_STUFF  = 2'd3;

    localparam logic [7:0] RST_ESCAPE = 8'h10;
    localparam logic [7:0] RST_START  = 8'h02;
    localparam logic [7:0] RST_END    = 8'h03;
    localparam logic [7:0] RST_STUFF  = 8'h00;

    // One classified input byte as handed from front to back.
    // pair: two data beats, first then second; otherwise one beat of kind.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] first;
        logic [7:0] second;
        logic       pair;
    } entry_t;

endpackage

### sv/dsd_front.sv
// ----------------------------------------------------------------------------
// dsd_front
// Frame hunter and escape classifier; holds the code registers.
// ----------------------------------------------------------------------------
module dsd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    input  logic           accept,
    input  logic [7:0]     rx_byte,
    output logic           wr_en,
    output dsd_pkg::entry_t wr_entry
);
    import dsd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT      = 2'd0,
        PH_HUNT_ESC  = 2'd1,
        PH_FRAME     = 2'd2,
        PH_FRAME_ESC = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] escape_reg, start_reg, end_reg, stuff_reg;
    logic       emit;

    always_comb
    begin
        phase_next      = phase_reg;
        emit            = 1'b0;
        wr_entry.kind   = KIND_DATA;
        wr_entry.first  = rx_byte;
        wr_entry.second = rx_byte;
        wr_entry.pair   = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == escape_reg)
                    phase_next = PH_HUNT_ESC;
            end
            PH_HUNT_ESC:
            begin
                if (rx_byte == start_reg)
                    phase_next = PH_FRAME;
                else if (rx_byte == escape_reg)
                    phase_next = PH_HUNT_ESC;
                else
                    phase_next = PH_HUNT;
            end
            PH_FRAME:
            begin
                if (rx_byte == escape_reg)
                    phase_next = PH_FRAME_ESC;
                else
                    emit = 1'b1;
            end
            PH_FRAME_ESC:
            begin
                emit       = 1'b1;
                phase_next = PH_FRAME;
                // stuff wins over end, end over start when codes coincide
                if (rx_byte == stuff_reg) begin
                    wr_entry.first = escape_reg;
                end else if (rx_byte == end_reg) begin
                    wr_entry.kind  = KIND_END;
                    wr_entry.first = 8'h00;
                    phase_next     = PH_HUNT;
                end else if (rx_byte == start_reg) begin
                    wr_entry.kind  = KIND_ABORT;
                    wr_entry.first = 8'h00;
                end else begin
                    wr_entry.first = escape_reg;
                    wr_entry.pair  = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    assign wr_en = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HUNT;
            escape_reg <= RST_ESCAPE;
            start_reg  <= RST_START;
            end_reg    <= RST_END;
            stuff_reg  <= RST_STUFF;
        end else begin
            if (accept)
                phase_reg <= phase_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ESCAPE: escape_reg <= cfg_data;
                    REG_START:  start_reg  <= cfg_data;
                    REG_END:    end_reg    <= cfg_data;
                    REG_STUFF:  stuff_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

endmodule

### sv/dsd_queue.sv
// ----------------------------------------------------------------------------
// dsd_queue
// Short flop-based queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module dsd_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  dsd_pkg::entry_t wr_entry,
    input  logic            rd_en,
    output dsd_pkg::entry_t rd_entry,
    output logic            full,
    output logic            empty
);
    import dsd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

### sv/dsd_back.sv
// ----------------------------------------------------------------------------
// dsd_back
// Expands queued entries into result beats held in an output register.
// ----------------------------------------------------------------------------
module dsd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  dsd_pkg::entry_t q_entry,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [1:0]      kind,
    output logic [7:0]      payload,
    output logic            run_last
);
    import dsd_pkg::*;

    logic       out_valid_reg;
    kind_t      kind_reg;
    logic [7:0] payload_reg;
    logic       last_reg;
    logic       pend_reg;
    logic [7:0] pend_byte_reg;
    logic       take;

    // output slot frees when empty or being taken this cycle
    assign take  = !out_valid_reg || pop;
    assign q_pop = take && !pend_reg && !q_empty;

    assign empty    = !out_valid_reg;
    assign kind     = kind_reg;
    assign payload  = payload_reg;
    assign run_last = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            kind_reg      <= KIND_DATA;
            payload_reg   <= 8'h00;
            last_reg      <= 1'b0;
            pend_byte_reg <= 8'h00;
        end else if (take) begin
            if (pend_reg) begin
                out_valid_reg <= 1'b1;
                kind_reg      <= KIND_DATA;
                payload_reg   <= pend_byte_reg;
                last_reg      <= 1'b1;
                pend_reg      <= 1'b0;
            end else if (!q_empty) begin
                out_valid_reg <= 1'b1;
                kind_reg      <= q_entry.kind;
                payload_reg   <= q_entry.first;
                last_reg      <= !q_entry.pair;
                pend_reg      <= q_entry.pair;
                pend_byte_reg <= q_entry.second;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> out_valid_reg && !last_reg)
        else $error("second beat pending without first beat shown");

    a_not_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> pend_reg && (kind_reg == KIND_DATA))
        else $error("non-final beat outside a byte pair");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pop) |=> (out_valid_reg && last_reg && !pend_reg))
        else $error("second beat of pair not delivered next");

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_DATA)) |-> (payload_reg == 8'h00) && last_reg)
        else $error("end or abort marker carries payload");

endmodule

### sv/dle_stx_etx_deframer.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer
// Escape/start/end byte-stuffing deframer, top level.
// ----------------------------------------------------------------------------
// Push received bytes while full is low: one byte is taken every cycle as
// long as the entry queue (QDEPTH deep) has room. Bytes outside a frame and
// the escape byte itself yield no result; every other byte yields one result
// beat, except an escape followed by an unrecognized byte, which yields two
// data beats. Results leave one beat per cycle, while pop is held, through
// a single output register; the first result of a byte passes through the
// entry queue and then the output register before it shows on the result
// ports. run_last marks the last beat of each byte. Write the code registers
// only while the block is idle.
module dle_stx_etx_deframer #(
    parameter int QDEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] kind,
    output logic [7:0] payload,
    output logic       run_last
);
    import dsd_pkg::*;

    logic   accept;
    logic   wr_en;
    entry_t wr_entry;
    entry_t rd_entry;
    logic   q_pop;
    logic   q_empty;

    assign accept = push && !full;

    dsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .wr_en     (wr_en),
        .wr_entry  (wr_entry)
    );

    dsd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_en    (q_pop),
        .rd_entry (rd_entry),
        .full     (full),
        .empty    (q_empty)
    );

    dsd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (rd_entry),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .kind     (kind),
        .payload  (payload),
        .run_last (run_last)
    );

endmodule

### tb/sv/dle_stx_etx_deframer_test.sv
// ----------------------------------------------------------------------------
// dle_stx_etx_deframer_test
// Self-checking bench for the byte-stuffing deframer.
// Received bytes are pushed from a pending queue. Each taken byte runs through
// a local deframer model that queues the beats it should produce. Popped beats
// are checked field by field against that queue. Random stalls are applied on
// both sides. Several code settings are used, including all-zero, all-ones and
// settings where codes coincide.
// ----------------------------------------------------------------------------
module dle_stx_etx_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dsd_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;

    typedef enum logic [1:0] {
        HUNT         = 2'd0,
        HUNT_ESC     = 2'd1,
        IN_FRAME     = 2'd2,
        IN_FRAME_ESC = 2'd3
    } link_phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload;
        logic       run_last;
    } frame_beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_index = REG_ESCAPE;
    logic [7:0] cfg_data  = 8'h00;
    logic       push      = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       pop       = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] kind;
    logic [7:0] payload;
    logic       run_last;

    // shadow of the code registers and the link state
    logic [7:0]  esc_code   = RST_ESCAPE;
    logic [7:0]  sof_code   = RST_START;
    logic [7:0]  eof_code   = RST_END;
    logic [7:0]  stuff_code = RST_STUFF;
    link_phase_t link_phase = HUNT;

    logic [7:0]  tx_q [$];
    frame_beat_t deframed_q [$];

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    bit tx_hold = 1'b0;
    int tx_gap  = 0;
    int rx_gap  = 0;

    int fail_cnt    = 0;
    int n_bytes     = 0;
    int n_beats     = 0;
    int n_ends      = 0;
    int n_aborts    = 0;
    int n_settings  = 1;
    int idle_cycles = 0;

    dle_stx_etx_deframer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .pop       (pop),
        .empty     (empty),
        .kind      (kind),
        .payload   (payload),
        .run_last  (run_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void emit_beat(input kind_t k, input logic [7:0] d, input logic last);
        frame_beat_t b;
        b.kind     = k;
        b.payload  = d;
        b.run_last = last;
        deframed_q.push_back(b);
        if (k == KIND_END)
            n_ends++;
        if (k == KIND_ABORT)
            n_aborts++;
    endfunction

    // one received byte through the link state machine
    function automatic void deframe_byte(input logic [7:0] b);
        case (link_phase)
            HUNT:
                if (b == esc_code)
                    link_phase = HUNT_ESC;
            HUNT_ESC:
                // start code wins over a repeated escape
                if (b == sof_code)
                    link_phase = IN_FRAME;
                else if (b == esc_code)
                    link_phase = HUNT_ESC;
                else
                    link_phase = HUNT;
            IN_FRAME:
                if (b == esc_code)
                    link_phase = IN_FRAME_ESC;
                else
                    emit_beat(KIND_DATA, b, 1'b1);
            default:
            begin
                // priority: stuff, end, start, then pass both through
                if (b == stuff_code) begin
                    emit_beat(KIND_DATA, esc_code, 1'b1);
                    link_phase = IN_FRAME;
                end else if (b == eof_code) begin
                    emit_beat(KIND_END, 8'h00, 1'b1);
                    link_phase = HUNT;
                end else if (b == sof_code) begin
                    emit_beat(KIND_ABORT, 8'h00, 1'b1);
                    link_phase = IN_FRAME;
                end else begin
                    emit_beat(KIND_DATA, esc_code, 1'b0);
                    emit_beat(KIND_DATA, b, 1'b1);
                    link_phase = IN_FRAME;
                end
            end
        endcase
    endfunction

    // driver: one byte per beat from tx_q
    always @(posedge clk)
    begin
        if (rst_n && push && !full) begin
            deframe_byte(rx_byte);
            n_bytes++;
        end
        if (!rst_n)
            push <= 1'b0;
        else if (push && full)
            push <= 1'b1;
        else if (tx_gap != 0) begin
            push <= 1'b0;
            tx_gap--;
        end else if (tx_hold || tx_q.size() == 0)
            push <= 1'b0;
        else if (tx_idle && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            tx_gap = $urandom_range(0, 3);
        end else begin
            push    <= 1'b1;
            rx_byte <= tx_q.pop_front();
        end
    end

    // monitor: check each popped beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty) begin
            n_beats++;
            if (deframed_q.size() == 0) begin
                $error("unexpected beat: kind %0d payload %0d run_last %0d",
                       kind, payload, run_last);
                fail_cnt++;
            end else begin
                if (kind !== deframed_q[0].kind) begin
                    $error("kind: expected %0d, actual %0d", deframed_q[0].kind, kind);
                    fail_cnt++;
                end
                if (payload !== deframed_q[0].payload) begin
                    $error("payload: expected %0d, actual %0d",
                           deframed_q[0].payload, payload);
                    fail_cnt++;
                end
                if (run_last !== deframed_q[0].run_last) begin
                    $error("run_last: expected %0d, actual %0d",
                           deframed_q[0].run_last, run_last);
                    fail_cnt++;
                end
                void'(deframed_q.pop_front());
            end
        end
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_gap != 0) begin
            pop <= 1'b0;
            rx_gap--;
        end else if (rx_idle && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            rx_gap = $urandom_range(0, 3);
        end else
            pop <= 1'b1;
    end

    // watchdog on cycles without any beat on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles", STALL_LIMIT);
            $display("FAIL dle_stx_etx_deframer");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_codes(input logic [7:0] e, input logic [7:0] s,
                               input logic [7:0] t, input logic [7:0] f);
        write_reg(REG_ESCAPE, e);
        write_reg(REG_START, s);
        write_reg(REG_END, t);
        write_reg(REG_STUFF, f);
        esc_code   = e;
        sof_code   = s;
        eof_code   = t;
        stuff_code = f;
        n_settings++;
    endtask

    function automatic logic [7:0] code_or_any();
        case ($urandom_range(0, 7))
            0: return esc_code;
            1: return sof_code;
            2: return eof_code;
            3: return stuff_code;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well-formed frames with random content, plus noise bursts
    function automatic void queue_traffic(input int n_items);
        int         stop_at;
        logic [7:0] b;
        stop_at = tx_q.size() + n_items;
        while (tx_q.size() < stop_at) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(0, 2))
                    tx_q.push_back(8'($urandom_range(0, 255)));
                tx_q.push_back(esc_code);
                tx_q.push_back(sof_code);
                repeat ($urandom_range(0, 12)) begin
                    if ($urandom_range(0, 15) == 0) begin
                        tx_q.push_back(esc_code);
                        tx_q.push_back(code_or_any());
                    end else begin
                        b = ($urandom_range(0, 3) == 0) ? code_or_any()
                                                        : 8'($urandom_range(0, 255));
                        tx_q.push_back(b);
                        if (b == esc_code)
                            tx_q.push_back(stuff_code);
                    end
                end
                // some frames are left open so the next header aborts them
                if ($urandom_range(0, 7) != 0) begin
                    tx_q.push_back(esc_code);
                    tx_q.push_back(eof_code);
                end
            end else begin
                repeat ($urandom_range(1, 8))
                    tx_q.push_back(code_or_any());
            end
        end
    endfunction

    task automatic run_phase(input bit idle_t, input bit idle_r, input bit hold_mid);
        int half;
        half    = tx_q.size() / 2;
        tx_idle = idle_t;
        rx_idle = idle_r;
        if (hold_mid) begin
            while (tx_q.size() > half)
                @(negedge clk);
            tx_hold = 1'b1;
            while (push || deframed_q.size() != 0)
                @(negedge clk);
            tx_hold = 1'b0;
        end
        while (tx_q.size() != 0 || push || deframed_q.size() != 0)
            @(negedge clk);
        // bytes that make no beat may still sit in the block
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset codes: escape 10, start 02, end 03, stuff 00
        tx_q = '{8'h00, 8'hFF, 8'h10, 8'h10, 8'h02,   // junk, repeated escape, header
                 8'h00, 8'hFF, 8'h55, 8'hAA,          // payload extremes
                 8'h10, 8'h00,                        // stuffed escape
                 8'h10, 8'h10,                        // escape escape: both pass
                 8'h10, 8'h7F,                        // escape other: both pass
                 8'h10, 8'h02,                        // abort by new header
                 8'h41, 8'h10, 8'h03,                 // byte then end
                 8'h10, 8'h41,                        // broken header
                 8'h10, 8'h02, 8'h10, 8'h03};         // empty frame
        run_phase(1'b1, 1'b1, 1'b0);

        apply_codes(8'h00, 8'hFF, 8'h80, 8'h7F);
        queue_traffic(220);
        run_phase(1'b1, 1'b1, 1'b1);

        apply_codes(8'hFF, 8'h00, 8'h01, 8'hFE);
        queue_traffic(220);
        run_phase(1'b1, 1'b0, 1'b0);

        // stuff, end and start share one code
        apply_codes(8'h55, 8'hAA, 8'hAA, 8'hAA);
        queue_traffic(220);
        run_phase(1'b0, 1'b1, 1'b0);

        // start equals end
        apply_codes(8'h7E, 8'h01, 8'h01, 8'h5D);
        queue_traffic(220);
        run_phase(1'b1, 1'b1, 1'b0);

        apply_codes(8'h00, 8'h00, 8'h00, 8'h00);
        queue_traffic(150);
        run_phase(1'b1, 1'b1, 1'b0);

        apply_codes(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_traffic(150);
        run_phase(1'b0, 1'b0, 1'b0);

        apply_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        queue_traffic(220);
        run_phase(1'b1, 1'b1, 1'b0);

        // closing stretch with no stalls
        apply_codes(RST_ESCAPE, RST_START, RST_END, RST_STUFF);
        queue_traffic(250);
        run_phase(1'b0, 1'b0, 1'b0);

        $display("covered %0d bytes and %0d beats over %0d code settings",
                 n_bytes, n_beats, n_settings);
        $display("frame ends %0d, aborts %0d, mismatches %0d", n_ends, n_aborts, fail_cnt);
        if (fail_cnt == 0)
            $display("PASS dle_stx_etx_deframer");
        else
            $display("FAIL dle_stx_etx_deframer");
        $finish;
    end

endmodule
